// ===== design/bmlcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap longest clear run: shared package
// Widths, lane geometry, segment summary type and the segment merge function.
// ----------------------------------------------------------------------------
package bmlcr_pkg;

  localparam int WORD_BITS = 32;
  localparam int LANE_BITS = 8;
  localparam int LANES     = WORD_BITS / LANE_BITS;
  localparam int LEVELS    = $clog2(LANES);
  localparam int MAX_BITS  = 65536;
  localparam int SIZE_W    = 17;
  localparam int INDEX_W   = 16;
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int POS_W     = INDEX_W - OFF_W;
  localparam int CNT_W     = $clog2(WORD_BITS + 1);

  // Summary of the clear runs inside one segment of a word
  typedef struct packed {
    logic             all_clr;  // every bit of the segment is clear
    logic [CNT_W-1:0] pre;      // clear bits from the low end
    logic [CNT_W-1:0] suf;      // clear bits from the high end
    logic [CNT_W-1:0] mx;       // longest clear run, earliest on a tie
    logic [OFF_W-1:0] mx_off;   // offset of that run within the segment
  } seg_t;

  // Sideband that travels with each item through the pipeline
  typedef struct packed {
    logic [INDEX_W-1:0] base;   // bit index of bit 0 of the word
    logic               last;   // word closes the scan
    logic               empty;  // size is zero: answer at once, touch nothing
  } meta_t;

  // Join a low segment l (lw bits wide) with the high segment r above it
  function automatic seg_t seg_combine(seg_t l, seg_t r, logic [CNT_W-1:0] lw);
    seg_t             res;
    logic [CNT_W-1:0] mid;
    logic [OFF_W-1:0] mid_off;
    begin
      res.all_clr = l.all_clr & r.all_clr;
      res.pre     = l.all_clr ? l.pre + r.pre : l.pre;
      res.suf     = r.all_clr ? r.suf + l.suf : r.suf;
      mid         = l.suf + r.pre;
      mid_off     = OFF_W'(lw - l.suf);
      res.mx      = l.mx;
      res.mx_off  = l.mx_off;
      // later candidates win only when strictly longer
      if (mid > res.mx) begin
        res.mx     = mid;
        res.mx_off = mid_off;
      end
      if (r.mx > res.mx) begin
        res.mx     = r.mx;
        res.mx_off = r.mx_off + OFF_W'(lw);
      end
      return res;
    end
  endfunction

endpackage

// ===== design/bmlcr_if.sv =====
// ----------------------------------------------------------------------------
// Bitmap longest clear run: channel interfaces
// Valid/ready channels for bitmap words in and scan results out.
// ----------------------------------------------------------------------------
interface bmlcr_word_if;
  import bmlcr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface bmlcr_result_if;
  import bmlcr_pkg::*;

  logic               valid;
  logic               ready;
  logic [SIZE_W-1:0]  run_length;
  logic [INDEX_W-1:0] start_index;

  modport source (output valid, output run_length, output start_index, input ready);
  modport sink   (input valid, input run_length, input start_index, output ready);
endinterface

// ===== design/bmlcr_lane.sv =====
// ----------------------------------------------------------------------------
// Bitmap longest clear run: lane
// Summarises the clear runs of one lane of a word and registers the summary.
// ----------------------------------------------------------------------------
module bmlcr_lane (
  input  logic                            clk,
  input  logic                            en,
  input  logic [bmlcr_pkg::LANE_BITS-1:0] lane_bits,
  output bmlcr_pkg::seg_t                 seg
);
  import bmlcr_pkg::*;

  seg_t seg_next;

  always_comb begin
    logic [CNT_W-1:0] run;
    logic             hit;
    seg_next = '0;
    // clear bits from the low end
    hit = 1'b0;
    for (int i = 0; i < LANE_BITS; i++) begin
      if (lane_bits[i]) hit = 1'b1;
      if (!hit) seg_next.pre = seg_next.pre + CNT_W'(1);
    end
    // clear bits from the high end
    hit = 1'b0;
    for (int i = LANE_BITS - 1; i >= 0; i--) begin
      if (lane_bits[i]) hit = 1'b1;
      if (!hit) seg_next.suf = seg_next.suf + CNT_W'(1);
    end
    // longest run, earliest kept on a tie
    run = '0;
    for (int i = 0; i < LANE_BITS; i++) begin
      run = lane_bits[i] ? '0 : run + CNT_W'(1);
      if (run > seg_next.mx) begin
        seg_next.mx     = run;
        seg_next.mx_off = OFF_W'(i) + OFF_W'(1) - OFF_W'(run);
      end
    end
    seg_next.all_clr = (seg_next.pre == CNT_W'(LANE_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg <= seg_next;
    end
  end

endmodule

// ===== design/bmlcr_merge.sv =====
// ----------------------------------------------------------------------------
// Bitmap longest clear run: lane merge
// Folds the lane summaries into one word summary through a tree, registered.
// ----------------------------------------------------------------------------
module bmlcr_merge (
  input  logic            clk,
  input  logic            en,
  input  bmlcr_pkg::seg_t lane_seg [bmlcr_pkg::LANES],
  output bmlcr_pkg::seg_t word_seg
);
  import bmlcr_pkg::*;

  // heap order: node 1 is the root, leaves sit at LANES .. 2*LANES-1
  seg_t node [2*LANES];

  always_comb begin
    int k;
    node[0] = '0;
    for (int j = 0; j < LANES; j++) begin
      node[LANES + j] = lane_seg[j];
    end
    for (int lv = 1; lv <= LEVELS; lv++) begin
      for (int j = 0; j < (LANES >> lv); j++) begin
        k       = (LANES >> lv) + j;
        node[k] = seg_combine(node[2*k], node[2*k + 1], CNT_W'(LANE_BITS << (lv - 1)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_seg <= node[1];
    end
  end

endmodule

// ===== design/bitmap_longest_clear_run_top.sv =====
// ----------------------------------------------------------------------------
// Bitmap longest clear run: top level
// Streams a bitmap one word per item and reports its longest clear run.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the result register is free to take a
// result; the scan state update, one add and two compares against the running best, sets that figure.
// Path: after the edge that accepts its last word, the result of a scan passes
// the lane stage, the merge stage and the output register, in that order.
// Reset: clears the size register, the scan state and all valid bits;
// there is no clearing pass and the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module bitmap_longest_clear_run_top (
  input  logic                         clk,
  input  logic                         rst,
  bmlcr_word_if.sink                   word_ch,
  bmlcr_result_if.source               result_ch,
  input  logic                         cfg_we,
  input  logic [bmlcr_pkg::SIZE_W-1:0] cfg_wdata
);
  import bmlcr_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration and word position
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] bitmap_size;
  logic [POS_W-1:0]  word_position;

  logic [SIZE_W-1:0] size_sat;
  logic [SIZE_W-1:0] base_ext;
  logic [SIZE_W-1:0] remaining;
  logic              at_end;
  logic              fits;
  logic              last_now;
  logic              empty_now;
  logic [CNT_W-1:0]  vcnt_now;

  // Saturate the size, then work out how many bits of this word count.
  always_comb begin
    size_sat  = (bitmap_size > SIZE_W'(MAX_BITS)) ? SIZE_W'(MAX_BITS) : bitmap_size;
    base_ext  = SIZE_W'({word_position, {OFF_W{1'b0}}});
    at_end    = (base_ext >= size_sat);
    remaining = size_sat - base_ext;
    fits      = (remaining <= SIZE_W'(WORD_BITS));
    last_now  = at_end || fits;
    empty_now = (size_sat == '0);
    if (at_end) begin
      vcnt_now = '0;
    end else if (fits) begin
      vcnt_now = CNT_W'(remaining);
    end else begin
      vcnt_now = CNT_W'(WORD_BITS);
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: each stage moves when the one after it has room
  // --------------------------------------------------------------------------
  logic  v0, v1, v2, out_v;
  meta_t s0_meta, s1_meta, s2_meta;
  logic  out_free, res2, fire3;
  logic  ready2, load2, ready1, load1, ready0, accept;

  assign out_free = !out_v || result_ch.ready;
  assign res2     = s2_meta.last || s2_meta.empty;
  assign fire3    = v2 && (!res2 || out_free);
  assign ready2   = !v2 || fire3;
  assign load2    = v1 && ready2;
  assign ready1   = !v1 || load2;
  assign load1    = v0 && ready1;
  assign ready0   = !v0 || load1;
  assign accept   = word_ch.valid && ready0;

  assign word_ch.ready = ready0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (accept)      v0 <= 1'b1;
      else if (load1)  v0 <= 1'b0;
      if (load1)       v1 <= 1'b1;
      else if (load2)  v1 <= 1'b0;
      if (load2)       v2 <= 1'b1;
      else if (fire3)  v2 <= 1'b0;
      if (fire3 && res2)         out_v <= 1'b1;
      else if (result_ch.ready)  out_v <= 1'b0;
    end
  end

  // Size register and position counter; a size write restarts the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap_size   <= '0;
      word_position <= '0;
    end else if (cfg_we) begin
      bitmap_size   <= cfg_wdata;
      word_position <= '0;
    end else if (accept && !empty_now) begin
      word_position <= last_now ? '0 : word_position + POS_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: hold the word with its valid bit count and sideband
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] s0_word;
  logic [CNT_W-1:0]     s0_vcnt;
  logic [WORD_BITS-1:0] s0_masked;

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_word       <= word_ch.data_word;
      s0_vcnt       <= vcnt_now;
      s0_meta.base  <= base_ext[INDEX_W-1:0];
      s0_meta.last  <= last_now;
      s0_meta.empty <= empty_now;
    end
  end

  // Force bits past the size to set, so they end any run and start none.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      s0_masked[i] = s0_word[i] | !(CNT_W'(i) < s0_vcnt);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: lanes summarise their slice of the word
  // --------------------------------------------------------------------------
  seg_t lane_seg [LANES];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bmlcr_lane u_lane (
      .clk       (clk),
      .en        (load1),
      .lane_bits (s0_masked[g*LANE_BITS +: LANE_BITS]),
      .seg       (lane_seg[g])
    );
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_meta <= s0_meta;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: merge the lanes into one word summary
  // --------------------------------------------------------------------------
  seg_t word_seg;

  bmlcr_merge u_merge (
    .clk      (clk),
    .en       (load2),
    .lane_seg (lane_seg),
    .word_seg (word_seg)
  );

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_meta <= s1_meta;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: fold the word summary into the scan state
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0]  current_run, best_run;
  logic [INDEX_W-1:0] current_start, best_start_pos;

  logic [SIZE_W-1:0]  ext_len, b1_len, b2_len, run_next;
  logic [INDEX_W-1:0] ext_start, b1_start, b2_start, start_next;

  always_comb begin
    // open run carried in, extended by the word's low clear bits
    ext_len   = current_run + SIZE_W'(word_seg.pre);
    ext_start = (current_run == '0) ? s2_meta.base : current_start;
    b1_len    = best_run;
    b1_start  = best_start_pos;
    if (ext_len > b1_len) begin
      b1_len   = ext_len;
      b1_start = ext_start;
    end
    // then the longest run found inside the word
    b2_len   = b1_len;
    b2_start = b1_start;
    if (SIZE_W'(word_seg.mx) > b1_len) begin
      b2_len   = SIZE_W'(word_seg.mx);
      b2_start = s2_meta.base + INDEX_W'(word_seg.mx_off);
    end
    // run still open at the top of the word
    if (word_seg.all_clr) begin
      run_next   = current_run + SIZE_W'(WORD_BITS);
      start_next = ext_start;
    end else begin
      run_next   = SIZE_W'(word_seg.suf);
      start_next = s2_meta.base + INDEX_W'(WORD_BITS) - INDEX_W'(word_seg.suf);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      current_run    <= '0;
      current_start  <= '0;
      best_run       <= '0;
      best_start_pos <= '0;
    end else if (fire3 && !s2_meta.empty) begin
      if (s2_meta.last) begin
        current_run    <= '0;
        current_start  <= '0;
        best_run       <= '0;
        best_start_pos <= '0;
      end else begin
        current_run    <= run_next;
        current_start  <= start_next;
        best_run       <= b2_len;
        best_start_pos <= b2_start;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold the result until it is taken
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0]  out_len;
  logic [INDEX_W-1:0] out_start;

  always_ff @(posedge clk) begin
    if (fire3 && res2) begin
      out_len   <= s2_meta.empty ? '0 : b2_len;
      out_start <= s2_meta.empty ? '0 : b2_start;
    end
  end

  assign result_ch.valid       = out_v;
  assign result_ch.run_length  = out_len;
  assign result_ch.start_index = out_start;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_open_run_within_best: assert property (
    @(posedge clk) disable iff (rst) current_run <= best_run
  ) else $error("open clear run longer than the best run");

  a_no_run_no_start: assert property (
    @(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.run_length == '0 |-> result_ch.start_index == '0
  ) else $error("start index given for an empty result");

  a_position_inside_size: assert property (
    @(posedge clk) disable iff (rst) size_sat != '0 |-> base_ext < size_sat
  ) else $error("word position past the bitmap size");

  a_last_word_clears: assert property (
    @(posedge clk) disable iff (rst)
    fire3 && s2_meta.last |=> current_run == '0 && best_run == '0
  ) else $error("scan state not cleared after the last word");

endmodule
